FILE: hdl/midi_channel_distributor_top_assert.svh
// Assertion macros shared by the MIDI channel distributor RTL.
`ifndef MIDI_CHANNEL_DISTRIBUTOR_TOP_ASSERT_SVH
`define MIDI_CHANNEL_DISTRIBUTOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define MCD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define MCD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MCD_ASSERT_IMP(lbl, ante, cons, msg)
`define MCD_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: hdl/mcd_pkg.sv
// Types and constants of the MIDI channel distributor.
`timescale 1ns / 1ps
package mcd_pkg;

	localparam int NUM_CHANNELS = 16;
	localparam int CH_W         = $clog2(NUM_CHANNELS);
	localparam int CNT_W        = $clog2(NUM_CHANNELS + 1);
	localparam int NOTE_W       = 7;
	localparam int CMD_W        = 3;
	localparam int STATUS_W     = 2;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 4;

	localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_STEAL   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_FIND    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ    = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_CHANNEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_CHANNEL = 2'd1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_ALLOC,
		S_STEAL_RD,
		S_STEAL_WR,
		S_REMOVE,
		S_READ_RD,
		S_READ_CHK,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		B_HOLD,
		B_PUSH,
		B_ROT_KEEP,
		B_ROT_DROP
	} busy_op_t;

	typedef enum logic [1:0] {
		F_HOLD,
		F_POP,
		F_PUSH
	} free_op_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [CH_W-1:0]     ch;
		logic [NOTE_W-1:0]   note;
	} res_t;

endpackage

FILE: hdl/mcd_if.sv
// Request and response channels of the MIDI channel distributor.
`timescale 1ns / 1ps
interface mcd_req_if;
	import mcd_pkg::*;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [NOTE_W-1:0] note;
	logic [CH_W-1:0]   channel;

	modport source (output valid, cmd, note, channel, input ready);
	modport sink (input valid, cmd, note, channel, output ready);
endinterface

interface mcd_rsp_if;
	import mcd_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [CH_W-1:0]     result_channel;
	logic [NOTE_W-1:0]   result_note;
	logic [CH_W-1:0]     oldest_busy;
	logic                oldest_busy_valid;
	logic [CH_W-1:0]     oldest_free;
	logic                oldest_free_valid;

	modport source (output valid, status, result_channel, result_note, oldest_busy,
		oldest_busy_valid, oldest_free, oldest_free_valid, input ready);
	modport sink (input valid, status, result_channel, result_note, oldest_busy,
		oldest_busy_valid, oldest_free, oldest_free_valid, output ready);
endinterface

FILE: hdl/midi_channel_distributor_top.sv
// Steal goes through S_STEAL_RD, S_STEAL_WR and S_DONE, note-of-channel through S_READ_RD,
// S_READ_CHK and S_DONE; find and allocate scan all 16 table entries through the single
// table read port, and release adds one rotation of the busy list per busy channel.
// One word is worked on at a time; the table scan sets the rate for most commands.
// Reset: table empty, busy FIFO empty, free FIFO holds channels 0 to 15. A range write
// rebuilds the same picture for the new range, with no clearing pass.
`timescale 1ns / 1ps
`include "midi_channel_distributor_top_assert.svh"
module midi_channel_distributor_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mcd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mcd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	mcd_req_if.sink                          req,
	mcd_rsp_if.source                        rsp
);
	import mcd_pkg::*;

	// Range registers and the rebuilt free list for a range write.
	logic [CH_W-1:0]  min_q, max_q;
	logic [CH_W-1:0]  new_min, new_max;
	logic             cfg_hit;
	logic [CNT_W-1:0] fill_cnt;

	// Note table: a small memory with one read and one write port. The empty
	// marks live in flip-flops so that a range write can clear them all at once.
	logic [NOTE_W-1:0] mem [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] valid_q;
	logic [NOTE_W-1:0] rd_data_q;
	logic              rd_vld_q;
	logic [CH_W-1:0]   rd_tag_q;
	logic [CH_W-1:0]   rd_addr;
	logic              mem_we;
	logic [CH_W-1:0]   mem_wa;
	logic              valid_set, valid_clr;

	// Busy and free FIFOs, kept as shift registers with the head at entry 0.
	logic [CH_W-1:0]  busy_q [NUM_CHANNELS];
	logic [CNT_W-1:0] busy_cnt_q;
	logic [CH_W-1:0]  free_q [NUM_CHANNELS];
	logic [CNT_W-1:0] free_cnt_q;
	busy_op_t         bop;
	free_op_t         fop;
	logic [CH_W-1:0]  busy_tail, free_tail;

	// Sequencer state.
	state_t           state_q, state_d;
	logic [CMD_W-1:0] cmd_q;
	logic [NOTE_W-1:0] note_q;
	logic [CH_W-1:0]  chan_q;
	logic [CH_W-1:0]  scan_q;
	logic             chk_q;
	logic             hit, last;
	logic [CNT_W-1:0] rot_q;
	logic             dropped_q;
	logic [CH_W-1:0]  ch_q;
	res_t             res_q, res_d;
	logic             res_we;
	logic             out_load;
	logic             req_ready;
	logic             accept;

	// Response register.
	logic             rsp_valid_q;
	res_t             rsp_res_q;
	logic [CH_W-1:0]  rsp_busy_q, rsp_free_q;
	logic             rsp_busy_v_q, rsp_free_v_q;

	assign accept = req.valid && req_ready;
	assign req.ready = req_ready;

	// A write to either range register rebuilds the whole block. The new range
	// combines the written value with the register that is not being written.
	assign cfg_hit = cfg_we && (cfg_index == REG_MIN_CHANNEL || cfg_index == REG_MAX_CHANNEL);
	assign new_min = (cfg_index == REG_MIN_CHANNEL) ? cfg_wdata[CH_W-1:0] : min_q;
	assign new_max = (cfg_index == REG_MAX_CHANNEL) ? cfg_wdata[CH_W-1:0] : max_q;
	assign fill_cnt = (new_max >= new_min) ?
		(CNT_W'(new_max) - CNT_W'(new_min) + CNT_W'(1)) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
			max_q <= CH_W'(NUM_CHANNELS - 1);
		end else if (cfg_hit) begin
			min_q <= new_min;
			max_q <= new_max;
		end
	end

	// The scan compares one table entry per cycle against the note of the word.
	// Read data arrive in the cycle after the address, tagged with that address.
	assign hit  = chk_q && rd_vld_q && (rd_data_q == note_q);
	assign last = chk_q && (rd_tag_q == CH_W'(NUM_CHANNELS - 1));

	assign busy_tail = CH_W'(busy_cnt_q - CNT_W'(1));
	assign free_tail = free_cnt_q[CH_W-1:0];

	always_comb begin
		state_d   = state_q;
		bop       = B_HOLD;
		fop       = F_HOLD;
		mem_we    = 1'b0;
		mem_wa    = free_q[0];
		valid_set = 1'b0;
		valid_clr = 1'b0;
		rd_addr   = scan_q;
		res_we    = 1'b0;
		res_d     = '{status: ST_NONE, ch: '0, note: '0};
		out_load  = 1'b0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req.valid) begin
					// Every word starts out as "none available"; the later
					// states overwrite the result where the command succeeds or finds a duplicate.
					res_we = 1'b1;
					if (req.cmd inside {CMD_ALLOC, CMD_RELEASE, CMD_FIND}) begin
						state_d = S_SCAN;
					end else if (req.cmd == CMD_STEAL) begin
						state_d = (busy_cnt_q != '0) ? S_STEAL_RD : S_DONE;
					end else if (req.cmd == CMD_READ) begin
						state_d = S_READ_RD;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_SCAN: begin
				rd_addr = scan_q;
				if (hit) begin
					case (cmd_q)
						CMD_ALLOC: begin
							res_we  = 1'b1;
							res_d   = '{status: ST_DUP, ch: rd_tag_q, note: '0};
							state_d = S_DONE;
						end
						CMD_RELEASE: begin
							// Empty the entry, hand the channel back to the free
							// list, then take it out of the busy list by rotation.
							res_we    = 1'b1;
							res_d     = '{status: ST_OK, ch: rd_tag_q, note: '0};
							valid_clr = 1'b1;
							fop       = F_PUSH;
							state_d   = S_REMOVE;
						end
						default: begin
							res_we  = 1'b1;
							res_d   = '{status: ST_OK, ch: rd_tag_q, note: '0};
							state_d = S_DONE;
						end
					endcase
				end else if (last) begin
					state_d = (cmd_q == CMD_ALLOC && free_cnt_q != '0) ? S_ALLOC : S_DONE;
				end
			end
			S_ALLOC: begin
				mem_we    = 1'b1;
				mem_wa    = free_q[0];
				valid_set = 1'b1;
				fop       = F_POP;
				bop       = B_PUSH;
				res_we    = 1'b1;
				res_d     = '{status: ST_OK, ch: free_q[0], note: '0};
				state_d   = S_DONE;
			end
			S_STEAL_RD: begin
				rd_addr = busy_q[0];
				state_d = S_STEAL_WR;
			end
			S_STEAL_WR: begin
				// The oldest channel takes the new note and moves to the tail.
				mem_we    = 1'b1;
				mem_wa    = busy_q[0];
				valid_set = 1'b1;
				bop       = B_ROT_KEEP;
				res_we    = 1'b1;
				res_d     = '{status: ST_OK, ch: busy_q[0],
					note: rd_vld_q ? rd_data_q : '1};
				state_d   = S_DONE;
			end
			S_REMOVE: begin
				// One full turn of the busy list keeps the order of the others.
				if (rot_q == '0) begin
					state_d = S_DONE;
				end else if (busy_q[0] == ch_q && !dropped_q) begin
					bop = B_ROT_DROP;
				end else begin
					bop = B_ROT_KEEP;
				end
			end
			S_READ_RD: begin
				rd_addr = chan_q;
				state_d = S_READ_CHK;
			end
			S_READ_CHK: begin
				if (rd_vld_q) begin
					res_we = 1'b1;
					res_d  = '{status: ST_OK, ch: '0, note: rd_data_q};
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Word fields, scan pointer and removal bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q     <= '0;
			note_q    <= '0;
			chan_q    <= '0;
			scan_q    <= '0;
			chk_q     <= 1'b0;
			rot_q     <= '0;
			dropped_q <= 1'b0;
			ch_q      <= '0;
			res_q     <= '{status: ST_NONE, ch: '0, note: '0};
		end else begin
			if (accept) begin
				cmd_q  <= req.cmd;
				note_q <= req.note;
				chan_q <= req.channel;
			end
			scan_q <= (state_q == S_SCAN) ? scan_q + CH_W'(1) : '0;
			chk_q  <= (state_q == S_SCAN) && (state_d == S_SCAN);
			if (state_q == S_SCAN) begin
				rot_q     <= busy_cnt_q;
				dropped_q <= 1'b0;
				ch_q      <= rd_tag_q;
			end else if (state_q == S_REMOVE && rot_q != '0) begin
				rot_q <= rot_q - CNT_W'(1);
				if (bop == B_ROT_DROP) begin
					dropped_q <= 1'b1;
				end
			end
			if (res_we) begin
				res_q <= res_d;
			end
		end
	end

	// Table memory and its read register.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= note_q;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_q <= 1'b0;
			rd_tag_q <= '0;
			valid_q  <= '0;
		end else begin
			rd_vld_q <= valid_q[rd_addr];
			rd_tag_q <= rd_addr;
			if (cfg_hit) begin
				valid_q <= '0;
			end else begin
				if (valid_set) begin
					valid_q[mem_wa] <= 1'b1;
				end
				if (valid_clr) begin
					valid_q[rd_tag_q] <= 1'b0;
				end
			end
		end
	end

	// Busy FIFO. A rotation shifts every entry one place towards the head and
	// either writes the old head back at the tail or drops it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NUM_CHANNELS; j++) begin
				busy_q[j] <= '0;
			end
			busy_cnt_q <= '0;
		end else if (cfg_hit) begin
			busy_cnt_q <= '0;
		end else begin
			case (bop)
				B_PUSH: begin
					if (busy_cnt_q < CNT_W'(NUM_CHANNELS)) begin
						busy_q[busy_cnt_q[CH_W-1:0]] <= free_q[0];
						busy_cnt_q <= busy_cnt_q + CNT_W'(1);
					end
				end
				B_ROT_KEEP: begin
					for (int j = 0; j < NUM_CHANNELS - 1; j++) begin
						busy_q[j] <= (CH_W'(j) == busy_tail) ? busy_q[0] : busy_q[j+1];
					end
					if (busy_tail == CH_W'(NUM_CHANNELS - 1)) begin
						busy_q[NUM_CHANNELS-1] <= busy_q[0];
					end
				end
				B_ROT_DROP: begin
					for (int j = 0; j < NUM_CHANNELS - 1; j++) begin
						busy_q[j] <= busy_q[j+1];
					end
					busy_cnt_q <= busy_cnt_q - CNT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// Free FIFO. A range write refills it with the range in ascending order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NUM_CHANNELS; j++) begin
				free_q[j] <= CH_W'(j);
			end
			free_cnt_q <= CNT_W'(NUM_CHANNELS);
		end else if (cfg_hit) begin
			for (int j = 0; j < NUM_CHANNELS; j++) begin
				free_q[j] <= new_min + CH_W'(j);
			end
			free_cnt_q <= fill_cnt;
		end else begin
			case (fop)
				F_POP: begin
					for (int j = 0; j < NUM_CHANNELS - 1; j++) begin
						free_q[j] <= free_q[j+1];
					end
					free_cnt_q <= free_cnt_q - CNT_W'(1);
				end
				F_PUSH: begin
					if (free_cnt_q < CNT_W'(NUM_CHANNELS)) begin
						free_q[free_tail] <= rd_tag_q;
						free_cnt_q <= free_cnt_q + CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Response register: it takes the result and the FIFO heads as they stand
	// once the command has finished, and holds them until the word is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_res_q    <= res_q;
			rsp_busy_v_q <= (busy_cnt_q != '0);
			rsp_busy_q   <= (busy_cnt_q != '0) ? busy_q[0] : '0;
			rsp_free_v_q <= (free_cnt_q != '0);
			rsp_free_q   <= (free_cnt_q != '0) ? free_q[0] : '0;
		end
	end

	assign rsp.valid             = rsp_valid_q;
	assign rsp.status            = rsp_res_q.status;
	assign rsp.result_channel    = rsp_res_q.ch;
	assign rsp.result_note       = rsp_res_q.note;
	assign rsp.oldest_busy       = rsp_busy_q;
	assign rsp.oldest_busy_valid = rsp_busy_v_q;
	assign rsp.oldest_free       = rsp_free_q;
	assign rsp.oldest_free_valid = rsp_free_v_q;

	// Every managed channel is in exactly one list, except while a released channel
	// is being taken out of the busy list, when it already sits in the free list too.
	`MCD_ASSERT_IMP(a_count_sum, 1'b1, ((CNT_W+1)'(busy_cnt_q) + (CNT_W+1)'(free_cnt_q)) <= ((CNT_W+1)'(NUM_CHANNELS) + (CNT_W+1)'(state_q == S_REMOVE)), "busy and free counts exceed the channel count")
	// Removing a released channel never grows the busy list.
	`MCD_ASSERT_NXT(a_remove_shrinks, state_q == S_REMOVE && !cfg_hit, busy_cnt_q <= $past(busy_cnt_q), "busy list grew during removal")
	// A new response word only appears from the done state.
	`MCD_ASSERT_IMP(a_rsp_from_done, $rose(rsp_valid_q), $past(state_q) == S_DONE, "response word raised outside the done state")
	// An allocated channel is marked as holding a note.
	`MCD_ASSERT_NXT(a_alloc_marks, state_q == S_ALLOC && !cfg_hit, valid_q[$past(free_q[0])], "allocated channel not marked as busy")

endmodule

FILE: tb/midi_channel_distributor_top_tb.sv
// Self-checking testbench for the MIDI channel distributor: directed and random command traffic.
`timescale 1ns / 1ps
module midi_channel_distributor_top_tb;
	import mcd_pkg::*;

	// Command codes the block does not know; they must come back as "none".
	localparam logic [CMD_W-1:0] CMD_BAD_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_BAD_HI = 3'd7;
	// A table entry with bit 7 set holds no note.
	localparam logic [7:0] NOTE_NONE = 8'hFF;
	// Settling time that covers the tail of the slowest command after the last word.
	localparam int DRAIN_CYCLES = 40;
	// Far beyond the slowest legal run, including every receiver stall.
	localparam int CYCLE_LIMIT = 500000;

	// Everything one result word carries, in the order the block reports it.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [CH_W-1:0]     ch;
		logic [NOTE_W-1:0]   note;
		logic [CH_W-1:0]     busy_head;
		logic                busy_head_v;
		logic [CH_W-1:0]     free_head;
		logic                free_head_v;
	} assignment_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	mcd_req_if req_ch ();
	mcd_rsp_if rsp_ch ();

	midi_channel_distributor_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always #2 clk = ~clk;

	// Our own picture of the block: the note table, both channel FIFOs and the range.
	logic [7:0]      tbl_note [NUM_CHANNELS];
	logic [CH_W-1:0] busy_q [$];
	logic [CH_W-1:0] free_q [$];
	int              lo_ch;
	int              hi_ch;

	// Results still owed by the block, oldest first.
	assignment_t pending_assignments [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int err_count     = 0;
	int cycle_count   = 0;
	int checked_count = 0;
	int unknown_hits  = 0;
	int range_writes  = 0;
	int cmd_hits [8];

	// Rebuilding the range empties the table and the busy FIFO, and lines up the
	// managed channels in ascending order in the free FIFO.
	task automatic rebuild_pool();
		int top;
		top = (hi_ch > NUM_CHANNELS - 1) ? NUM_CHANNELS - 1 : hi_ch;
		foreach (tbl_note[c]) tbl_note[c] = NOTE_NONE;
		busy_q.delete();
		free_q.delete();
		for (int c = lo_ch; c <= top && free_q.size() < NUM_CHANNELS; c++)
			free_q.push_back(c[CH_W-1:0]);
	endtask

	// The lowest managed channel that plays the given note, or -1 when none does.
	function automatic int holder_of(input logic [NOTE_W-1:0] nt);
		int top;
		top = (hi_ch > NUM_CHANNELS - 1) ? NUM_CHANNELS - 1 : hi_ch;
		for (int c = lo_ch; c <= top; c++)
			if (tbl_note[c] == {1'b0, nt})
				return c;
		return -1;
	endfunction

	// Carries out one command on our picture and works out the word it must produce.
	task automatic predict_assignment(input logic [CMD_W-1:0] op, input logic [NOTE_W-1:0] nt,
			input logic [CH_W-1:0] qc, output assignment_t r);
		int              holder;
		logic [CH_W-1:0] c;
		r        = '0;
		r.status = ST_NONE;
		holder   = holder_of(nt);
		case (op)
			CMD_ALLOC: begin
				if (holder >= 0) begin
					r.status = ST_DUP;
					r.ch     = holder[CH_W-1:0];
				end else if (free_q.size() > 0) begin
					c           = free_q.pop_front();
					tbl_note[c] = {1'b0, nt};
					if (busy_q.size() < NUM_CHANNELS) busy_q.push_back(c);
					r.status    = ST_OK;
					r.ch        = c;
				end
			end
			CMD_STEAL: begin
				// The oldest voice is taken over and goes to the back of the busy FIFO.
				if (busy_q.size() > 0) begin
					c           = busy_q.pop_front();
					r.note      = tbl_note[c][NOTE_W-1:0];
					tbl_note[c] = {1'b0, nt};
					if (busy_q.size() < NUM_CHANNELS) busy_q.push_back(c);
					r.status    = ST_OK;
					r.ch        = c;
				end
			end
			CMD_RELEASE: begin
				if (holder >= 0) begin
					c           = holder[CH_W-1:0];
					tbl_note[c] = NOTE_NONE;
					for (int i = 0; i < busy_q.size(); i++) begin
						if (busy_q[i] == c) begin
							busy_q.delete(i);
							break;
						end
					end
					if (free_q.size() < NUM_CHANNELS) free_q.push_back(c);
					r.status = ST_OK;
					r.ch     = c;
				end
			end
			CMD_FIND: begin
				if (holder >= 0) begin
					r.status = ST_OK;
					r.ch     = holder[CH_W-1:0];
				end
			end
			CMD_READ: begin
				if (!tbl_note[qc][7]) begin
					r.status = ST_OK;
					r.note   = tbl_note[qc][NOTE_W-1:0];
				end
			end
			default: begin
			end
		endcase
		if (busy_q.size() > 0) begin
			r.busy_head   = busy_q[0];
			r.busy_head_v = 1'b1;
		end
		if (free_q.size() > 0) begin
			r.free_head   = free_q[0];
			r.free_head_v = 1'b1;
		end
	endtask

	// Offers one command word, idling first as the current sender setting asks. The task is
	// entered at a rising edge and returns at the edge that accepted the word. The valid line
	// is left high, so the next word follows back to back unless the sender idles.
	task automatic send_word(input logic [CMD_W-1:0] op, input logic [NOTE_W-1:0] nt,
			input logic [CH_W-1:0] qc);
		assignment_t want;
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.cmd     <= op;
		req_ch.note    <= nt;
		req_ch.channel <= qc;
		do @(posedge clk); while (!req_ch.ready);
		predict_assignment(op, nt, qc, want);
		pending_assignments.push_back(want);
		if (op > CMD_READ) unknown_hits++;
		else cmd_hits[op]++;
	endtask

	// Stops offering words and waits until every owed result has come back and the block
	// has had time to settle.
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (pending_assignments.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One register write; write enable drops again afterwards so that writes stay apart.
	task automatic write_range_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		if (idx == REG_MIN_CHANNEL) lo_ch = int'(val);
		else hi_ch = int'(val);
		rebuild_pool();
		range_writes++;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_range(input int lo, input int hi);
		wait_idle();
		write_range_reg(REG_MIN_CHANNEL, lo[CFG_DATA_W-1:0]);
		write_range_reg(REG_MAX_CHANNEL, hi[CFG_DATA_W-1:0]);
	endtask

	// Straight after reset nothing is held, so every lookup and the steal must fail, and
	// the unknown command codes must fail too.
	task automatic test_empty_table();
		send_word(CMD_READ, '0, '0);
		send_word(CMD_STEAL, 7'd64, '0);
		send_word(CMD_RELEASE, 7'd5, '0);
		send_word(CMD_FIND, 7'd127, '0);
		for (int op = CMD_BAD_LO; op <= CMD_BAD_HI; op++)
			send_word(op[CMD_W-1:0], 7'd127, 4'd15);
	endtask

	// Allocation, the duplicate check, lookups both ways and a steal that leaves the same
	// note on two channels, so that find and release must pick the lower one.
	task automatic test_alloc_and_steal();
		send_word(CMD_ALLOC, 7'd0, '0);
		send_word(CMD_ALLOC, 7'd127, '0);
		send_word(CMD_ALLOC, 7'd0, '0);
		send_word(CMD_FIND, 7'd127, '0);
		send_word(CMD_READ, '0, 4'd1);
		send_word(CMD_STEAL, 7'd127, 4'd15);
		send_word(CMD_FIND, 7'd127, '0);
		send_word(CMD_RELEASE, 7'd127, '0);
		send_word(CMD_RELEASE, 7'd127, '0);
		send_word(CMD_READ, '0, 4'd15);
	endtask

	// A single channel at the top, an empty range, and a single channel at the bottom.
	task automatic test_range_extremes();
		apply_range(15, 15);
		send_word(CMD_ALLOC, 7'd9, '0);
		send_word(CMD_ALLOC, 7'd10, '0);
		send_word(CMD_READ, '0, 4'd15);
		send_word(CMD_READ, '0, 4'd0);
		apply_range(15, 0);
		send_word(CMD_ALLOC, 7'd1, '0);
		send_word(CMD_STEAL, 7'd2, '0);
		apply_range(0, 0);
		send_word(CMD_ALLOC, 7'd1, '0);
		send_word(CMD_STEAL, 7'd2, '0);
		send_word(CMD_RELEASE, 7'd2, '0);
	endtask

	// Three idling regimes, each with three range settings. Most notes come from a narrow
	// window so that duplicates, finds and releases actually hit held voices, while small
	// ranges fill up and force steals; the rest are drawn from the whole note range.
	task automatic test_random_traffic();
		int              pick;
		int              lo;
		int              hi;
		int              pool_base;
		logic [CMD_W-1:0]  op;
		logic [NOTE_W-1:0] nt;
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 16;
					recv_idle_pct = 54;
				end
				1: begin
					send_idle_pct = 54;
					recv_idle_pct = 16;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int blk = 0; blk < 3; blk++) begin
				pick = $urandom_range(9);
				if (pick == 0) begin
					lo = 0;
					hi = NUM_CHANNELS - 1;
				end else if (pick == 1) begin
					lo = $urandom_range(15, 1);
					hi = $urandom_range(lo - 1);
				end else if (pick == 2) begin
					lo = $urandom_range(15);
					hi = lo;
				end else begin
					lo = $urandom_range(15);
					hi = lo + $urandom_range(15 - lo);
				end
				apply_range(lo, hi);
				pool_base = $urandom_range(116);
				repeat (50) begin
					pick = $urandom_range(99);
					if (pick < 35) op = CMD_ALLOC;
					else if (pick < 50) op = CMD_STEAL;
					else if (pick < 75) op = CMD_RELEASE;
					else if (pick < 85) op = CMD_FIND;
					else if (pick < 95) op = CMD_READ;
					else op = CMD_W'($urandom_range(CMD_BAD_HI, CMD_BAD_LO));
					if ($urandom_range(99) < 80) nt = NOTE_W'(pool_base + $urandom_range(11));
					else nt = NOTE_W'($urandom_range(127));
					send_word(op, nt, CH_W'($urandom_range(15)));
				end
			end
		end
	endtask

	task automatic compare_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endtask

	// The receiver takes result words at random, as the current setting asks.
	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Every result word taken is checked against the oldest owed result.
	always @(posedge clk) begin
		assignment_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_assignments.size() == 0) begin
				$error("result word arrived with no command outstanding");
				err_count++;
			end else begin
				want = pending_assignments.pop_front();
				compare_field("status", 8'(want.status), 8'(rsp_ch.status));
				compare_field("result_channel", 8'(want.ch), 8'(rsp_ch.result_channel));
				compare_field("result_note", 8'(want.note), 8'(rsp_ch.result_note));
				compare_field("oldest_busy", 8'(want.busy_head), 8'(rsp_ch.oldest_busy));
				compare_field("oldest_busy_valid", 8'(want.busy_head_v),
					8'(rsp_ch.oldest_busy_valid));
				compare_field("oldest_free", 8'(want.free_head), 8'(rsp_ch.oldest_free));
				compare_field("oldest_free_valid", 8'(want.free_head_v),
					8'(rsp_ch.oldest_free_valid));
				checked_count++;
			end
		end
	end

	// A hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_wdata      = '0;
		req_ch.valid   = 1'b0;
		req_ch.cmd     = '0;
		req_ch.note    = '0;
		req_ch.channel = '0;
		foreach (cmd_hits[i]) cmd_hits[i] = 0;
		lo_ch = 0;
		hi_ch = NUM_CHANNELS - 1;
		rebuild_pool();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_empty_table();
		test_alloc_and_steal();
		test_range_extremes();
		test_random_traffic();
		wait_idle();

		$display("Covered %0d range writes and commands: alloc %0d, steal %0d, release %0d,",
			range_writes, cmd_hits[CMD_ALLOC], cmd_hits[CMD_STEAL], cmd_hits[CMD_RELEASE]);
		$display("  find %0d, read %0d, unknown %0d; %0d result words checked.",
			cmd_hits[CMD_FIND], cmd_hits[CMD_READ], unknown_hits, checked_count);
		if (err_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: files.f
+incdir+hdl
hdl/mcd_pkg.sv
hdl/mcd_if.sv
hdl/midi_channel_distributor_top.sv
tb/midi_channel_distributor_top_tb.sv
